// File: rtl/phma_pkg.sv
// Shared types, field widths and price constants for the price history averager.
package phma_pkg;

    localparam int PRICE_W     = 48;
    localparam int CHANGE_W    = 17;
    localparam int CHANGE_FRAC = 16;
    localparam int SYM_IN_W    = 3;
    localparam int PERIOD_W    = 16;

    localparam logic [CHANGE_W-1:0] CHANGE_ONE = 17'h10000;

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // Prices in hundredths, converted to fixed point at elaboration
    localparam logic [63:0] HUND_SYM0  = 64'd4200000;
    localparam logic [63:0] HUND_SYM1  = 64'd270000;
    localparam logic [63:0] HUND_SYM2  = 64'd9500;
    localparam logic [63:0] HUND_SYM3  = 64'd48;
    localparam logic [63:0] HUND_SYM4  = 64'd95;
    localparam logic [63:0] HUND_ONE   = 64'd100;
    localparam logic [63:0] HUND_FLOOR = 64'd1;
    localparam logic [63:0] HUND_CAP0  = 64'd10000000;
    localparam logic [63:0] HUND_CAP1  = 64'd1000000;

    typedef struct packed {
        logic                mode;
        logic [CHANGE_W-1:0] change_a;
        logic [CHANGE_W-1:0] change_b;
        logic [CHANGE_W-1:0] change_c;
        logic [CHANGE_W-1:0] change_d;
        logic [CHANGE_W-1:0] change_e;
        logic [SYM_IN_W-1:0] which_symbol;
        logic [PERIOD_W-1:0] period_count;
    } phma_cmd_t;

    typedef struct packed {
        logic [PRICE_W-1:0] average_price;
        logic               bad_symbol;
    } phma_rsp_t;

    // Hundredths to fixed point, rounded half up; called with constants only
    function automatic logic [PRICE_W-1:0] from_hundredths(
        input logic [63:0] hundredths,
        input int          frac_bits
    );
        logic [63:0] scaled;
        scaled = (hundredths << frac_bits) + 64'd50;
        return PRICE_W'(scaled / 64'd100);
    endfunction

endpackage

// File: rtl/phma_price_store.sv
// Current price memory: one entry per symbol, reset values via written bits.
module phma_price_store #(
    parameter int SYMBOL_COUNT  = 5,
    parameter int FRACTION_BITS = 16,
    localparam int ADDR_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [phma_pkg::PRICE_W-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [phma_pkg::PRICE_W-1:0] wr_data
);
    import phma_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    localparam logic [PRICE_W-1:0] RESET_TABLE [8] = '{
        from_hundredths(HUND_SYM0, FRACTION_BITS),
        from_hundredths(HUND_SYM1, FRACTION_BITS),
        from_hundredths(HUND_SYM2, FRACTION_BITS),
        from_hundredths(HUND_SYM3, FRACTION_BITS),
        from_hundredths(HUND_SYM4, FRACTION_BITS),
        from_hundredths(HUND_ONE, FRACTION_BITS),
        from_hundredths(HUND_ONE, FRACTION_BITS),
        from_hundredths(HUND_ONE, FRACTION_BITS)
    };

    logic [PRICE_W-1:0] mem [DEPTH];
    logic [PRICE_W-1:0] data_reg;
    logic [DEPTH-1:0]   written_reg;
    logic               hit_reg;
    logic [ADDR_W-1:0]  addr_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
            addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= written_reg[rd_addr];
            end
        end
    end

    // never-written entry reads as its reset price
    assign rd_data = hit_reg ? data_reg : RESET_TABLE[3'(addr_reg)];

endmodule

// File: rtl/phma_ring_store.sv
// Snapshot ring memory: one write and one registered read port.
module phma_ring_store #(
    parameter int ADDR_W = 9
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [phma_pkg::PRICE_W-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [phma_pkg::PRICE_W-1:0] wr_data
);
    import phma_pkg::*;

    logic [PRICE_W-1:0] mem [2 ** ADDR_W];
    logic [PRICE_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = data_reg;

endmodule

// File: rtl/phma_div.sv
// Restoring divider, one quotient bit per cycle.
module phma_div #(
    parameter int DIVIDEND_W = 55,
    parameter int DIVISOR_W  = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);
    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  run_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        fits    = (shifted >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= STEP_W'(DIVIDEND_W);
                run_reg  <= 1'b1;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/price_history_moving_average.sv
// Price history moving average: top level with sequencer over the price and ring memories.
// Record beat: busy throughout, pipelined price read-modify-write.
// Query beat, accept to result: a bad symbol is answered directly, a zero window returns
// the current price from one price read, and an n-deep window takes n ring reads,
// then a serial divide. One beat at a time; busy is high meanwhile, except for a bad symbol.
// done marks rsp for one cycle, no receiver stall; async rst_n restores start prices at once.
module price_history_moving_average #(
    parameter int HISTORY_DEPTH = 64,
    parameter int SYMBOL_COUNT  = 5,
    parameter int FRACTION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  phma_pkg::phma_cmd_t cmd,
    output logic                done,
    output phma_pkg::phma_rsp_t rsp
);
    import phma_pkg::*;

    localparam int SYM_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int IDX_W   = $clog2(SYMBOL_COUNT + 1);
    localparam int SUM_W   = PRICE_W + CNT_W;
    localparam int RING_AW = SLOT_W + SYM_W;
    localparam int WIDE_W  = PRICE_W + 2;

    localparam logic [SLOT_W-1:0]   LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0]    FULL_CNT  = CNT_W'(HISTORY_DEPTH);
    localparam logic [IDX_W-1:0]    LAST_IDX  = IDX_W'(SYMBOL_COUNT);
    localparam logic [SYM_IN_W:0]   SYM_LIMIT = (SYM_IN_W + 1)'(SYMBOL_COUNT);

    // Floor and caps, converted like the start prices
    localparam logic [WIDE_W-1:0] FLOOR_V =
        WIDE_W'(from_hundredths(HUND_FLOOR, FRACTION_BITS));
    localparam logic [WIDE_W-1:0] CAP0_V =
        WIDE_W'(from_hundredths(HUND_CAP0, FRACTION_BITS));
    localparam logic [WIDE_W-1:0] CAP1_V =
        WIDE_W'(from_hundredths(HUND_CAP1, FRACTION_BITS));
    localparam logic [WIDE_W-1:0] SAT_V = WIDE_W'({PRICE_W{1'b1}});

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_REC  = 3'd1;   // read, snapshot, scale each symbol
    localparam logic [2:0] ST_QRD  = 3'd2;   // walk the ring backwards, summing
    localparam logic [2:0] ST_DIV  = 3'd3;   // wait on the divider
    localparam logic [2:0] ST_CUR  = 3'd4;   // current price read in flight

    logic [2:0]        state_reg,  state_next;
    phma_cmd_t         cmd_reg,    cmd_next;
    logic [CNT_W-1:0]  stored_reg, stored_next;
    logic [SLOT_W-1:0] wslot_reg,  wslot_next;
    logic [SLOT_W-1:0] rslot_reg,  rslot_next;
    logic [IDX_W-1:0]  idx_reg,    idx_next;
    logic              pend_reg,   pend_next;
    logic [SYM_W-1:0]  psym_reg,   psym_next;
    logic [CNT_W-1:0]  left_reg,   left_next;
    logic [CNT_W-1:0]  n_reg,      n_next;
    logic [SUM_W-1:0]  sum_reg,    sum_next;
    logic              done_reg,   done_next;
    phma_rsp_t         rsp_reg,    rsp_next;

    // Memory and divider hookup
    logic               price_rd_en, price_wr_en;
    logic [SYM_W-1:0]   price_rd_addr;
    logic [PRICE_W-1:0] price_rd, price_wr;
    logic               ring_rd_en, ring_wr_en;
    logic [RING_AW-1:0] ring_rd_addr, ring_wr_addr;
    logic [PRICE_W-1:0] ring_rd;
    logic               div_start, div_done;
    logic [SUM_W-1:0]   div_quo;

    // Price update datapath
    logic [CHANGE_W-1:0] chg;
    logic [31:0]         p_hi;
    logic [15:0]         p_lo;
    logic [48:0]         prod_hi;
    logic [32:0]         prod_lo;
    logic [WIDE_W-1:0]   scaled;
    logic [WIDE_W-1:0]   limited;

    // Query setup
    logic [SYM_W-1:0]    q_sym;
    logic [CNT_W-1:0]    q_n;
    logic [SLOT_W-1:0]   newest_slot;

    phma_price_store #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_price (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (price_rd_en),
        .rd_addr(price_rd_addr),
        .rd_data(price_rd),
        .wr_en  (price_wr_en),
        .wr_addr(psym_reg),
        .wr_data(price_wr)
    );

    phma_ring_store #(
        .ADDR_W(RING_AW)
    ) u_ring (
        .clk    (clk),
        .rd_en  (ring_rd_en),
        .rd_addr(ring_rd_addr),
        .rd_data(ring_rd),
        .wr_en  (ring_wr_en),
        .wr_addr(ring_wr_addr),
        .wr_data(price_rd)
    );

    phma_div #(
        .DIVIDEND_W(SUM_W),
        .DIVISOR_W (CNT_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(sum_reg),
        .divisor (n_reg),
        .done    (div_done),
        .quotient(div_quo)
    );

    // Change factor for the symbol whose price just came back
    always_comb
    begin
        case (psym_reg)
            SYM_W'(0): chg = cmd_reg.change_a;
            SYM_W'(1): chg = (SYMBOL_COUNT > 1) ? cmd_reg.change_b : CHANGE_ONE;
            SYM_W'(2): chg = (SYMBOL_COUNT > 2) ? cmd_reg.change_c : CHANGE_ONE;
            SYM_W'(3): chg = (SYMBOL_COUNT > 3) ? cmd_reg.change_d : CHANGE_ONE;
            SYM_W'(4): chg = (SYMBOL_COUNT > 4) ? cmd_reg.change_e : CHANGE_ONE;
            default:   chg = CHANGE_ONE;
        endcase
    end

    // floor(p * c / 2^16) split into two narrow products
    always_comb
    begin
        p_hi    = price_rd[PRICE_W-1:CHANGE_FRAC];
        p_lo    = price_rd[CHANGE_FRAC-1:0];
        prod_hi = p_hi * chg;
        prod_lo = p_lo * chg;
        scaled  = WIDE_W'(prod_hi) + WIDE_W'(prod_lo[32:CHANGE_FRAC]);
        limited = scaled;
        if (limited < FLOOR_V)
        begin
            limited = FLOOR_V;
        end
        if ((psym_reg == SYM_W'(0)) && (limited > CAP0_V))
        begin
            limited = CAP0_V;
        end
        if ((SYMBOL_COUNT > 1) && (psym_reg == SYM_W'(1)) && (limited > CAP1_V))
        begin
            limited = CAP1_V;
        end
        if (limited > SAT_V)
        begin
            limited = SAT_V;
        end
        price_wr = limited[PRICE_W-1:0];
    end

    // Window length and newest stored slot for a query
    always_comb
    begin
        q_sym = cmd.which_symbol[SYM_W-1:0];
        if (cmd.period_count < PERIOD_W'(stored_reg))
        begin
            q_n = CNT_W'(cmd.period_count);
        end
        else
        begin
            q_n = stored_reg;
        end
        newest_slot = (wslot_reg == '0) ? LAST_SLOT : wslot_reg - 1'b1;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        stored_next = stored_reg;
        wslot_next  = wslot_reg;
        rslot_next  = rslot_reg;
        idx_next    = idx_reg;
        pend_next   = 1'b0;
        psym_next   = psym_reg;
        left_next   = left_reg;
        n_next      = n_reg;
        sum_next    = sum_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;

        price_rd_en   = 1'b0;
        price_rd_addr = idx_reg[SYM_W-1:0];
        price_wr_en   = 1'b0;
        ring_rd_en    = 1'b0;
        ring_rd_addr  = {rslot_reg, cmd_reg.which_symbol[SYM_W-1:0]};
        ring_wr_en    = 1'b0;
        ring_wr_addr  = {wslot_reg, psym_reg};
        div_start     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    if (cmd.mode == MODE_RECORD)
                    begin
                        idx_next   = '0;
                        state_next = ST_REC;
                    end
                    else if ({1'b0, cmd.which_symbol} >= SYM_LIMIT)
                    begin
                        rsp_next.average_price = '0;
                        rsp_next.bad_symbol    = 1'b1;
                        done_next              = 1'b1;
                    end
                    else if (q_n == '0)
                    begin
                        price_rd_en   = 1'b1;
                        price_rd_addr = q_sym;
                        state_next    = ST_CUR;
                    end
                    else
                    begin
                        n_next     = q_n;
                        left_next  = q_n;
                        rslot_next = newest_slot;
                        sum_next   = '0;
                        state_next = ST_QRD;
                    end
                end
            end

            ST_REC:
            begin
                // read symbol idx while the previous one is written back
                if (idx_reg != LAST_IDX)
                begin
                    price_rd_en = 1'b1;
                    pend_next   = 1'b1;
                    psym_next   = idx_reg[SYM_W-1:0];
                    idx_next    = idx_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    ring_wr_en  = 1'b1;
                    price_wr_en = 1'b1;
                end
                if ((idx_reg == LAST_IDX) && !pend_reg)
                begin
                    wslot_next = (wslot_reg == LAST_SLOT) ? '0 : wslot_reg + 1'b1;
                    if (stored_reg != FULL_CNT)
                    begin
                        stored_next = stored_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_QRD:
            begin
                if (left_reg != '0)
                begin
                    ring_rd_en = 1'b1;
                    pend_next  = 1'b1;
                    left_next  = left_reg - 1'b1;
                    rslot_next = (rslot_reg == '0) ? LAST_SLOT : rslot_reg - 1'b1;
                end
                if (pend_reg)
                begin
                    sum_next = sum_reg + SUM_W'(ring_rd);
                end
                if ((left_reg == '0) && !pend_reg)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    rsp_next.average_price = div_quo[PRICE_W-1:0];
                    rsp_next.bad_symbol    = 1'b0;
                    done_next              = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            ST_CUR:
            begin
                rsp_next.average_price = price_rd;
                rsp_next.bad_symbol    = 1'b0;
                done_next              = 1'b1;
                state_next             = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        rslot_reg <= rslot_next;
        psym_reg  <= psym_next;
        n_reg     <= n_next;
        sum_reg   <= sum_next;
        rsp_reg   <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            stored_reg <= '0;
            wslot_reg  <= '0;
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
            left_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            stored_reg <= stored_next;
            wslot_reg  <= wslot_next;
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
            left_reg   <= left_next;
            done_reg   <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
